>>> src/escaped_message_field_splitter_unit_defines.svh
// Assertion macros shared by the field splitter RTL.
`ifndef ESCAPED_MESSAGE_FIELD_SPLITTER_UNIT_DEFINES_SVH
`define ESCAPED_MESSAGE_FIELD_SPLITTER_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define EMFS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define EMFS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/emfs_pkg.sv
// Types and constants for the escaped message field splitter.
package emfs_pkg;

    // Width of the event accumulator; the low 32 bits are reported
    localparam int EVENT_BITS = 32;
    localparam int EVENT_OUT_BITS = 32;
    localparam int WIDE_BITS = 64;

    // Delimiter bytes
    localparam logic [7:0] CH_COLON     = 8'h3A;
    localparam logic [7:0] CH_HASH      = 8'h23;
    localparam logic [7:0] CH_EQUALS    = 8'h3D;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;

    // Field kind codes on the output
    localparam logic [2:0] KIND_EVENT     = 3'd0;
    localparam logic [2:0] KIND_NAME      = 3'd1;
    localparam logic [2:0] KIND_DATA      = 3'd2;
    localparam logic [2:0] KIND_OPT_NAME  = 3'd3;
    localparam logic [2:0] KIND_OPT_VALUE = 3'd4;

    // Parser phase
    typedef enum logic [2:0] {
        PH_EV_START = 3'd0,
        PH_EV_BODY  = 3'd1,
        PH_NAME     = 3'd2,
        PH_DATA     = 3'd3,
        PH_OPT_NAME = 3'd4,
        PH_OPT_VAL  = 3'd5
    } phase_t;

    // One input byte with its end mark
    typedef struct packed {
        logic [7:0] byte_in;
        logic       end_of_message;
    } item_t;

    // One tagged result
    typedef struct packed {
        logic [7:0]                byte_out;
        logic [2:0]                field_kind;
        logic                      is_content;
        logic                      field_closed;
        logic [EVENT_OUT_BITS-1:0] event_value;
        logic                      event_ready;
        logic                      message_done;
        logic                      malformed;
    } result_t;

endpackage

>>> src/emfs_in_stage.sv
// Input register stage: captures one byte transfer at a time.
module emfs_in_stage
    import emfs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] byte_in,
    input  logic       end_of_message,
    input  logic       take,
    output logic       item_valid,
    output item_t      item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    item_t item_next;

    // Free when empty or when the held item moves on this cycle
    assign in_ready = !valid_reg || take;

    always_comb
    begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
            if (in_valid)
            begin
                item_next.byte_in        = byte_in;
                item_next.end_of_message = end_of_message;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

>>> src/emfs_parser.sv
// Field parser: phase, escape history and event accumulator, one byte per step.
module emfs_parser
    import emfs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step,
    input  item_t   item,
    output result_t result
);

    phase_t                phase_reg;
    phase_t                phase_next;
    phase_t                ph_after;
    logic                  last_bs_reg;
    logic                  last_bs_next;
    logic                  second_bs_reg;
    logic                  second_bs_next;
    logic [EVENT_BITS-1:0] acc_reg;
    logic [EVENT_BITS-1:0] acc_next;
    logic [EVENT_BITS-1:0] acc_upd;
    logic [WIDE_BITS-1:0]  acc_wide;
    logic                  escaped;
    logic [7:0]            b;
    logic                  eom;
    logic [2:0]            kind;
    logic                  content;
    logic                  closed;
    logic                  ev_ready;
    logic                  bad;
    logic                  in_event;

    assign b        = item.byte_in;
    assign eom      = item.end_of_message;
    assign escaped  = last_bs_reg && !second_bs_reg;
    assign in_event = (phase_reg == PH_EV_START) || (phase_reg == PH_EV_BODY);

    // Per-byte decode of the current field
    always_comb
    begin
        ph_after = phase_reg;
        kind     = KIND_EVENT;
        content  = 1'b1;
        closed   = 1'b0;
        ev_ready = 1'b0;
        acc_upd  = acc_reg;
        unique case (phase_reg)
            PH_EV_START:
            begin
                acc_upd  = EVENT_BITS'(b);
                ph_after = PH_EV_BODY;
            end
            PH_EV_BODY:
            begin
                if (b == CH_COLON)
                begin
                    content  = 1'b0;
                    closed   = 1'b1;
                    ev_ready = 1'b1;
                    ph_after = PH_NAME;
                end
                else
                begin
                    acc_upd = EVENT_BITS'({acc_reg, b});
                end
            end
            PH_NAME:
            begin
                kind = KIND_NAME;
                if (b == CH_COLON && !escaped)
                begin
                    content  = 1'b0;
                    closed   = 1'b1;
                    ph_after = PH_DATA;
                end
            end
            PH_DATA:
            begin
                kind = KIND_DATA;
                if (b == CH_HASH && !escaped)
                begin
                    content  = 1'b0;
                    closed   = 1'b1;
                    ph_after = PH_OPT_NAME;
                end
            end
            PH_OPT_NAME:
            begin
                kind = KIND_OPT_NAME;
                if ((b == CH_EQUALS || b == CH_HASH) && !escaped)
                begin
                    content  = 1'b0;
                    closed   = 1'b1;
                    ph_after = (b == CH_EQUALS) ? PH_OPT_VAL : PH_OPT_NAME;
                end
            end
            PH_OPT_VAL:
            begin
                kind = KIND_OPT_VALUE;
                if (b == CH_HASH && !escaped)
                begin
                    content  = 1'b0;
                    closed   = 1'b1;
                    ph_after = PH_OPT_NAME;
                end
            end
            default:
            begin
                acc_upd  = EVENT_BITS'(b);
                ph_after = PH_EV_BODY;
            end
        endcase
    end

    // End of message closes whatever is open and flags an early end
    assign bad = eom && (in_event || (phase_reg == PH_NAME && ph_after != PH_DATA));

    assign acc_wide = WIDE_BITS'(acc_upd);

    always_comb
    begin
        result.byte_out     = b;
        result.field_kind   = kind;
        result.is_content   = content;
        result.field_closed = closed || eom;
        result.event_value  = acc_wide[EVENT_OUT_BITS-1:0];
        result.event_ready  = ev_ready || (eom && in_event);
        result.message_done = eom;
        result.malformed    = bad;
    end

    // State update on each step; end of message returns to reset values
    always_comb
    begin
        phase_next     = phase_reg;
        last_bs_next   = last_bs_reg;
        second_bs_next = second_bs_reg;
        acc_next       = acc_reg;
        if (step)
        begin
            if (eom)
            begin
                phase_next     = PH_EV_START;
                last_bs_next   = 1'b0;
                second_bs_next = 1'b0;
                acc_next       = '0;
            end
            else
            begin
                phase_next     = ph_after;
                second_bs_next = last_bs_reg;
                last_bs_next   = (b == CH_BACKSLASH);
                acc_next       = acc_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_EV_START;
            last_bs_reg   <= 1'b0;
            second_bs_reg <= 1'b0;
            acc_reg       <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            last_bs_reg   <= last_bs_next;
            second_bs_reg <= second_bs_next;
            acc_reg       <= acc_next;
        end
    end

endmodule

>>> src/emfs_out_stage.sv
// Result register stage: holds one tagged byte until the transfer completes.
module emfs_out_stage
    import emfs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t result,
    output logic    space,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t held
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    // Room for a new result when empty or when the held one leaves now
    assign space = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (space)
        begin
            valid_next = load;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= result;
        end
    end

    assign out_valid = valid_reg;
    assign held      = res_reg;

endmodule

>>> src/escaped_message_field_splitter_unit.sv
// Top level of the escaped message field splitter.
//
//   channel | signals                                   | direction
//   in      | in_valid, in_ready, byte_in, end_of_message | into block
//   out     | out_valid, out_ready, byte_out .. malformed | out of block
//
// A transferred byte passes through the input register and then the result
// register. One byte per cycle is sustained while the output is not stalled,
// set by the single parser step between the input and result registers.
// A stalled output holds its result while one more byte waits in the input
// register. Reset clears valid flags and parser state.
`include "escaped_message_field_splitter_unit_defines.svh"

module escaped_message_field_splitter_unit
    import emfs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  byte_in,
    input  logic        end_of_message,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  byte_out,
    output logic [2:0]  field_kind,
    output logic        is_content,
    output logic        field_closed,
    output logic [31:0] event_value,
    output logic        event_ready,
    output logic        message_done,
    output logic        malformed
);

    logic    item_valid;
    item_t   item;
    logic    space;
    logic    advance;
    result_t result;
    result_t held;

    // A byte moves from input register to result register
    assign advance = item_valid && space;

    emfs_in_stage u_in (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .byte_in        (byte_in),
        .end_of_message (end_of_message),
        .take           (advance),
        .item_valid     (item_valid),
        .item           (item)
    );

    emfs_parser u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (item),
        .result (result)
    );

    emfs_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance),
        .result    (result),
        .space     (space),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .held      (held)
    );

    assign byte_out     = held.byte_out;
    assign field_kind   = held.field_kind;
    assign is_content   = held.is_content;
    assign field_closed = held.field_closed;
    assign event_value  = held.event_value;
    assign event_ready  = held.event_ready;
    assign message_done = held.message_done;
    assign malformed    = held.malformed;

    // Consistency of the tagged result
    `EMFS_ASSERT_NOW(a_malformed_at_end, out_valid && malformed, message_done && field_closed, "malformed flag away from message end")
    `EMFS_ASSERT_NOW(a_event_ready_kind, out_valid && event_ready, field_kind == KIND_EVENT && field_closed, "event ready outside a closing event byte")
    `EMFS_ASSERT_NOW(a_delim_closes, out_valid && !is_content, field_closed, "delimiter that does not close a field")
    `EMFS_ASSERT_NEXT(a_result_follows, advance, out_valid, "advanced byte did not reach the result register")

endmodule
